@@ rtl/asls_pkg.sv @@
// Shared widths, codes and handshake structs for the ADC speed LED scanner.
// No dependencies; every other file in rtl/ imports this package.
package asls_pkg;

    localparam int LED_COUNT   = 8;
    localparam int SAMPLE_BITS = 12;

    localparam int SAMPLE_W = SAMPLE_BITS;
    localparam int LEVEL_W  = SAMPLE_BITS + 1;
    localparam int SUM_W    = LEVEL_W + 1;
    localparam int CNT_W    = 16;
    localparam int ZONE_W   = 12;
    localparam int SPEED_W  = 16;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W     = (LEVEL_W > CNT_W) ? LEVEL_W : CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // average update: floor(sum / 5) as (sum * ceil(2^22 / 5)) >> 22, exact for sum < 2^22
    localparam int AVG_SUM_W   = SAMPLE_W + 3;
    localparam int AVG_SHIFT   = 22;
    localparam int AVG_RECIP_W = AVG_SHIFT - 2;
    localparam int AVG_PROD_W  = AVG_SUM_W + AVG_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'((2**AVG_SHIFT + 4) / 5);

    localparam logic [LEVEL_W-1:0]   LEVEL_TOP  = LEVEL_W'(1) << SAMPLE_W;
    localparam logic [LED_COUNT-1:0] LED_LOW    = LED_COUNT'(1);
    localparam logic [LED_COUNT-1:0] LED_HIGH   = LED_COUNT'(1) << (LED_COUNT - 1);
    localparam logic [CNT_W-1:0]     CNT_RESET  = CNT_W'(10);

    localparam logic [ZONE_W-1:0]  DEADBAND_RESET = ZONE_W'(13);
    localparam logic [ZONE_W-1:0]  UPPER_RESET    = ZONE_W'(4092);
    localparam logic [ZONE_W-1:0]  LOWER_RESET    = ZONE_W'(20);
    localparam logic [SPEED_W-1:0] SPEED_RESET    = SPEED_W'(40000);

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/asls_if.sv @@
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on asls_pkg for field widths.
interface asls_in_if;
    import asls_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, command, sample, input ready);
    modport sink   (input valid, command, sample, output ready);
endinterface

interface asls_out_if;
    import asls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [LED_COUNT-1:0] led_pattern;
    logic [LEVEL_W-1:0]   level;
    logic                 level_updated;
    logic                 stepped;
    modport source (output valid, led_pattern, level, level_updated, stepped, input ready);
    modport sink   (input valid, led_pattern, level, level_updated, stepped, output ready);
endinterface

interface asls_cfg_if;
    import asls_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/adc_speed_led_scanner.sv @@
// Top level of the ADC speed LED scanner: sequencer, state and output register.
// Depends on asls_pkg, the interfaces in asls_if.sv and the divider asls_div.
//
// Usage:
//   i_in_chan  : one transaction per item; command 0 = ADC sample, 1 = timer tick,
//                2 = run toggle, 3 = report only. sample is read on command 0.
//   o_out_chan : exactly one result transaction per item, in order.
//   i_cfg_chan : register writes (0 deadband, 1 upper zone, 2 lower zone,
//                3 speed numerator), always ready; write only while idle.
// Sequence:
//   A tick whose countdown expires runs the divider (DIV_W = 16 quotient bits)
//   in S_DIV before S_FIN registers its result; the next item can be taken in
//   the cycle after that. Other items go from S_IDLE straight to S_FIN.
//   One item is in flight at a time; ready is low while it is being worked.
// Reset: synchronous, active low; registers return to their defaults, the LED
//   row is dark, the countdown is 10 and the scanner is running.
// Stall: a result waits in the output register; the next item can be accepted
//   meanwhile but its result is held back until the register frees up.
module adc_speed_led_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asls_in_if.sink    i_in_chan,
    asls_out_if.source o_out_chan,
    asls_cfg_if.sink   i_cfg_chan
);
    import asls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    logic [ZONE_W-1:0]  r_deadband;
    logic [ZONE_W-1:0]  r_upper;
    logic [ZONE_W-1:0]  r_lower;
    logic [SPEED_W-1:0] r_speed;

    logic [SAMPLE_W-1:0]  r_avg;
    logic [LEVEL_W-1:0]   r_level;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic                 r_run;
    logic [LED_COUNT-1:0] r_led;
    logic                 r_up;

    logic [CMD_W-1:0]     r_cmd;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [AVG_SUM_W-1:0] r_sum;

    logic                 r_out_valid;
    logic [LED_COUNT-1:0] r_out_led;
    logic [LEVEL_W-1:0]   r_out_level;
    logic                 r_out_upd;
    logic                 r_out_stp;

    logic [SAMPLE_W-1:0]  n_avg;
    logic [LEVEL_W-1:0]   n_level;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_pend;
    logic                 n_run;
    logic [LED_COUNT-1:0] n_led;
    logic                 n_up;
    logic                 upd;
    logic                 stp;

    logic                  in_acc;
    logic                  out_free;
    logic                  fin_go;
    logic                  expiring;
    logic [AVG_PROD_W-1:0] avg_prod;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    asls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in_chan.ready  = (r_state == S_IDLE);
    assign i_cfg_chan.ready = 1'b1;
    assign in_acc   = i_in_chan.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out_chan.ready;
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign expiring = (r_cnt <= CNT_W'(1));

    always_comb begin
        div_req.start    = in_acc && (i_in_chan.command == CMD_TICK) && expiring;
        div_req.dividend = DIV_W'(r_speed);
        div_req.divisor  = DIV_W'(r_level) + DIV_W'(2);
    end

    always_comb begin
        avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_RECIP);
        n_avg   = r_avg;
        n_level = r_level;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_run   = r_run;
        n_led   = r_led;
        n_up    = r_up;
        upd     = 1'b0;
        stp     = 1'b0;
        unique case (r_cmd)
            CMD_SAMPLE: begin
                n_avg = avg_prod[AVG_SHIFT +: SAMPLE_W];
                if ((SUM_W'(n_avg) > SUM_W'(r_level) + SUM_W'(r_deadband)) ||
                    (SUM_W'(n_avg) + SUM_W'(r_deadband) < SUM_W'(r_level))) begin
                    n_level = LEVEL_W'(n_avg);
                    upd     = 1'b1;
                end else if (SUM_W'(r_sample) > SUM_W'(r_upper)) begin
                    n_level = LEVEL_TOP;
                    upd     = 1'b1;
                end else if (SUM_W'(r_sample) < SUM_W'(r_lower)) begin
                    n_level = '0;
                    upd     = 1'b1;
                end
            end
            CMD_TICK: begin
                if (expiring) begin
                    n_cnt  = div_rsp.quotient[CNT_W-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
                stp = r_run && n_pend;
            end
            CMD_TOGGLE: begin
                n_run = !r_run;
                stp   = n_run && r_pend;
            end
            default: begin
            end
        endcase
        if (stp) begin
            n_pend = 1'b0;
            if (r_led == '0) begin
                n_led = LED_LOW;
            end else if (r_up) begin
                if (r_led != LED_HIGH) begin
                    n_led = r_led << 1;
                end else begin
                    n_up  = 1'b0;
                    n_led = r_led >> 1;
                end
            end else begin
                if (r_led != LED_LOW) begin
                    n_led = r_led >> 1;
                end else begin
                    n_up  = 1'b1;
                    n_led = r_led << 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_level     <= '0;
            r_cnt       <= CNT_RESET;
            r_pend      <= 1'b0;
            r_run       <= 1'b1;
            r_led       <= '0;
            r_up        <= 1'b1;
        end else begin
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_chan.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= div_req.start ? S_DIV : S_FIN;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        r_avg   <= n_avg;
                        r_level <= n_level;
                        r_cnt   <= n_cnt;
                        r_pend  <= n_pend;
                        r_run   <= n_run;
                        r_led   <= n_led;
                        r_up    <= n_up;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_in_chan.command;
            r_sample <= i_in_chan.sample;
            r_sum    <= AVG_SUM_W'(i_in_chan.sample) + (AVG_SUM_W'(r_avg) << 2);
        end
        if (fin_go) begin
            r_out_led   <= n_led;
            r_out_level <= n_level;
            r_out_upd   <= upd;
            r_out_stp   <= stp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
            r_upper    <= UPPER_RESET;
            r_lower    <= LOWER_RESET;
            r_speed    <= SPEED_RESET;
        end else if (i_cfg_chan.valid) begin
            unique case (i_cfg_chan.index)
                CFG_DEADBAND: r_deadband <= i_cfg_chan.data[ZONE_W-1:0];
                CFG_UPPER:    r_upper    <= i_cfg_chan.data[ZONE_W-1:0];
                CFG_LOWER:    r_lower    <= i_cfg_chan.data[ZONE_W-1:0];
                CFG_SPEED:    r_speed    <= i_cfg_chan.data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_chan.valid         = r_out_valid;
    assign o_out_chan.led_pattern   = r_out_led;
    assign o_out_chan.level         = r_out_level;
    assign o_out_chan.level_updated = r_out_upd;
    assign o_out_chan.stepped       = r_out_stp;

endmodule

@@ rtl/asls_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// The sequencer's divider for the step reload (speed over level plus two). Uses asls_pkg.
module asls_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asls_pkg::t_div_req i_req,
    output asls_pkg::t_div_rsp o_rsp
);
    import asls_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic [DIV_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W:0]   rem_sh;
    logic             fits;
    logic [DIV_W:0]   n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        rem_sh = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
        n_rem  = fits ? rem_sh - {1'b0, r_div} : rem_sh;
        n_quo  = {r_quo[DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == LAST_STEP);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/asls_chk.sv @@
// Port-level checker for adc_speed_led_scanner, attached by the bind below.
// Depends on asls_pkg and the top level's channel interfaces.
module asls_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [asls_pkg::LED_COUNT-1:0] i_led_pattern,
    input logic [asls_pkg::LEVEL_W-1:0]   i_level,
    input logic                           i_level_updated,
    input logic                           i_stepped
);
    import asls_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_led_pattern) &&
        $stable(i_level) && $stable(i_level_updated) && $stable(i_stepped)))
        else $error("stalled result changed");

    a_led_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($onehot0(i_led_pattern) && (i_level <= LEVEL_TOP)))
        else $error("bad led pattern or level range");

    a_step_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stepped) |-> (i_led_pattern != '0))
        else $error("step left the row dark");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_stepped && i_level_updated))
        else $error("level update and step on one item");

endmodule

bind adc_speed_led_scanner asls_chk u_asls_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_chan.valid),
    .i_in_ready      (i_in_chan.ready),
    .i_out_valid     (o_out_chan.valid),
    .i_out_ready     (o_out_chan.ready),
    .i_led_pattern   (o_out_chan.led_pattern),
    .i_level         (o_out_chan.level),
    .i_level_updated (o_out_chan.level_updated),
    .i_stepped       (o_out_chan.stepped)
);

@@ verif/testbench.sv @@
// Self-checking bench for adc_speed_led_scanner: directed rows, then random phases
// under several register settings; results checked vs typed rows or local predictor.
// Depends on asls_pkg and the channel interfaces in rtl/asls_if.sv.
module testbench;
    import asls_pkg::*;

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int PHASE_ITEMS   = 135;
    localparam int PHASE_COUNT   = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [LED_COUNT-1:0] led;
        logic [LEVEL_W-1:0]   level;
        logic                 updated;
        logic                 stepped;
    } scan_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SAMPLE_W-1:0]  smp;
        logic                 typed;
        logic [LED_COUNT-1:0] led;
        logic [LEVEL_W-1:0]   level;
        logic                 updated;
        logic                 stepped;
    } scan_row_t;

    logic i_clk;
    logic i_rst_n;

    asls_in_if  in_ch();
    asls_out_if out_ch();
    asls_cfg_if cfg_ch();

    adc_speed_led_scanner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_ch),
        .o_out_chan (out_ch),
        .i_cfg_chan (cfg_ch)
    );

    // scanner state as predicted
    logic [SAMPLE_W-1:0]  avg_q;
    logic [LEVEL_W-1:0]   level_q;
    logic [CNT_W-1:0]     count_q;
    logic                 pend_q;
    logic                 run_q;
    logic [LED_COUNT-1:0] leds_q;
    logic                 up_q;

    logic [ZONE_W-1:0]  db_r  = DEADBAND_RESET;
    logic [ZONE_W-1:0]  upz_r = UPPER_RESET;
    logic [ZONE_W-1:0]  loz_r = LOWER_RESET;
    logic [SPEED_W-1:0] spd_r = SPEED_RESET;

    scan_result_t        scan_results_due[$];
    int                  mismatches = 0;
    bit                  calm = 1'b0;
    logic [SAMPLE_W-1:0] held_sample = '0;

    scan_row_t opening_rows [22] = '{
        '{CMD_REPORT, 12'd0,    1'b1, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'd0,    1'b1, 8'h00, 13'd0,   1'b1, 1'b0},
        '{CMD_SAMPLE, 12'd4095, 1'b1, 8'h00, 13'd819, 1'b1, 1'b0},
        '{CMD_TOGGLE, 12'd0,    1'b1, 8'h00, 13'd819, 1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd4095, 1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_TOGGLE, 12'd0,    1'b1, 8'h01, 13'd819, 1'b0, 1'b1},
        '{CMD_TICK,   12'd0,    1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'd4095, 1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'd4093, 1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_REPORT, 12'd4095, 1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'd2048, 1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'hAAA,  1'b0, 8'h00, 13'd0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 12'h555,  1'b0, 8'h00, 13'd0,   1'b0, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void move_light();
        if (leds_q == '0) begin
            leds_q = LED_LOW;
        end else if (up_q) begin
            if (leds_q != LED_HIGH) begin
                leds_q = leds_q << 1;
            end else begin
                up_q   = 1'b0;
                leds_q = leds_q >> 1;
            end
        end else if (leds_q != LED_LOW) begin
            leds_q = leds_q >> 1;
        end else begin
            up_q   = 1'b1;
            leds_q = leds_q << 1;
        end
        pend_q = 1'b0;
    endfunction

    function automatic scan_result_t advance_scanner(input logic [CMD_W-1:0] cmd,
                                                     input logic [SAMPLE_W-1:0] smp);
        scan_result_t r;
        int unsigned  av;
        int unsigned  lv;
        int unsigned  db;
        r  = '0;
        case (cmd)
            CMD_SAMPLE: begin
                av    = (int'(smp) + 4 * int'(avg_q)) / 5;
                avg_q = SAMPLE_W'(av);
                av    = 32'(avg_q);
                lv    = 32'(level_q);
                db    = 32'(db_r);
                if (av > lv + db || av + db < lv) begin
                    level_q   = LEVEL_W'(av);
                    r.updated = 1'b1;
                end else if (smp > upz_r) begin
                    level_q   = LEVEL_TOP;
                    r.updated = 1'b1;
                end else if (smp < loz_r) begin
                    level_q   = '0;
                    r.updated = 1'b1;
                end
            end
            CMD_TICK: begin
                if (count_q <= CNT_W'(1)) begin
                    count_q = CNT_W'(int'(spd_r) / (int'(level_q) + 2));
                    pend_q  = 1'b1;
                end else begin
                    count_q = count_q - 1'b1;
                end
                if (run_q && pend_q) begin
                    move_light();
                    r.stepped = 1'b1;
                end
            end
            CMD_TOGGLE: begin
                run_q = ~run_q;
                if (run_q && pend_q) begin
                    move_light();
                    r.stepped = 1'b1;
                end
            end
            default: ;
        endcase
        r.led   = leds_q;
        r.level = level_q;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return CMD_SAMPLE;
        if (roll < 85) return CMD_TICK;
        if (roll < 93) return CMD_TOGGLE;
        return CMD_REPORT;
    endfunction

    // runs of one value let the average settle inside the deadband
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return held_sample;
        if (roll < 50) held_sample = $urandom_range(0, 1) ? '1 : '0;
        else if (roll < 65) held_sample = SAMPLE_W'($urandom_range(4080, 4095));
        else if (roll < 75) held_sample = SAMPLE_W'($urandom_range(0, 40));
        else held_sample = SAMPLE_W'($urandom_range(0, 4095));
        return held_sample;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp,
                             input logic typed, input scan_result_t typed_res);
        int           gap;
        scan_result_t due;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.sample  <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        due = advance_scanner(cmd, smp);
        scan_results_due.push_back(typed ? typed_res : due);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_DEADBAND: db_r  = ZONE_W'(data);
            CFG_UPPER:    upz_r = ZONE_W'(data);
            CFG_LOWER:    loz_r = ZONE_W'(data);
            CFG_SPEED:    spd_r = SPEED_W'(data);
            default: ;
        endcase
    endtask

    task automatic load_registers(input logic [ZONE_W-1:0] db, input logic [ZONE_W-1:0] up,
                                  input logic [ZONE_W-1:0] lo, input logic [SPEED_W-1:0] sp);
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_register(CFG_DEADBAND, CFG_DATA_W'(db));
        write_register(CFG_UPPER, CFG_DATA_W'(up));
        write_register(CFG_LOWER, CFG_DATA_W'(lo));
        write_register(CFG_SPEED, CFG_DATA_W'(sp));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // result side: random stalls, check each transaction
    initial begin
        int           stall;
        scan_result_t want;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (scan_results_due.size() == 0) begin
                    note_mismatch("unexpected result, level", -1, int'(out_ch.level));
                end else begin
                    want = scan_results_due.pop_front();
                    if (out_ch.led_pattern !== want.led)
                        note_mismatch("led_pattern", want.led, out_ch.led_pattern);
                    if (out_ch.level !== want.level)
                        note_mismatch("level", want.level, out_ch.level);
                    if (out_ch.level_updated !== want.updated)
                        note_mismatch("level_updated", want.updated, out_ch.level_updated);
                    if (out_ch.stepped !== want.stepped)
                        note_mismatch("stepped", want.stepped, out_ch.stepped);
                end
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        logic [ZONE_W-1:0]  db;
        logic [ZONE_W-1:0]  up;
        logic [ZONE_W-1:0]  lo;
        logic [SPEED_W-1:0] sp;
        scan_row_t          row;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_REPORT;
        in_ch.sample  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_DEADBAND;
        cfg_ch.data   <= '0;

        avg_q   = '0;
        level_q = '0;
        count_q = CNT_RESET;
        pend_q  = 1'b0;
        run_q   = 1'b1;
        leds_q  = '0;
        up_q    = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[n]) begin
            row = opening_rows[n];
            send_item(row.cmd, row.smp, row.typed,
                      '{row.led, row.level, row.updated, row.stepped});
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                in_ch.valid <= 1'b0;
                case (ph)
                    1: begin db = '0;   up = '1;   lo = '0;   sp = '0;          end
                    2: begin db = '1;   up = '0;   lo = '1;   sp = '1;          end
                    3: begin db = '0;   up = '0;   lo = '1;   sp = 16'd1;       end
                    4: begin
                        db = ZONE_W'(40);
                        up = ZONE_W'(4000);
                        lo = ZONE_W'(100);
                        sp = 16'd3000;
                    end
                    5: begin
                        db = ZONE_W'($urandom_range(0, 200));
                        up = ZONE_W'($urandom_range(3500, 4095));
                        lo = ZONE_W'($urandom_range(0, 600));
                        sp = SPEED_W'($urandom_range(0, 20000));
                    end
                    6: begin
                        db = ZONE_W'($urandom_range(0, 4095));
                        up = ZONE_W'($urandom_range(0, 4095));
                        lo = ZONE_W'($urandom_range(0, 4095));
                        sp = SPEED_W'($urandom_range(0, 65535));
                    end
                    default: begin
                        db = DEADBAND_RESET;
                        up = UPPER_RESET;
                        lo = LOWER_RESET;
                        sp = 16'd2000;
                    end
                endcase
                load_registers(db, up, lo, sp);
            end
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_item(pick_command(), pick_sample(), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && scan_results_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
